>>> design/vpp_pkg.sv
// ----------------------------------------------------------------------------
// vpp_pkg
// shared types and constants of the perspective vertex projection pipeline
// ----------------------------------------------------------------------------
package vpp_pkg;

	// register file
	localparam int REG_W     = 63;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALFW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HALFH = 3'd6;

	// datapath widths
	localparam int COEF_MAX_W = 21;  // widest coefficient, narrower ones sign extend
	localparam int COEF_FRAC  = 12;
	localparam int OFS_W      = 21;
	localparam int VERT_W     = 32;
	localparam int T_W        = 34;  // translated coordinate
	localparam int P_W        = 54;  // coefficient times coordinate
	localparam int S_W        = 56;  // row sum
	localparam int Q_W        = 45;  // rotated coordinate in 29.16
	localparam int X_W        = 48;  // x and y after scale by five
	localparam int ZD_W       = 46;  // z plus shifted depth perception
	localparam int D_W        = 46;  // divisor
	localparam int MUL_W      = 14;  // numerator multiplier
	localparam int N_W        = 64;  // signed numerator
	localparam int M_W        = 63;  // numerator magnitude, quotient
	localparam int OUT_W      = 16;
	localparam int HALF_W     = 14;
	localparam int DP_W       = 16;

	// remainder by 2^15-1 through folding of 15-bit chunks
	localparam int MOD_W      = 15;
	localparam int MOD_CHUNKS = (M_W + MOD_W - 1) / MOD_W;
	localparam int FOLD_W     = 18;
	localparam logic [MOD_W:0] SCREEN_MOD = 16'd32767;

	localparam logic [DP_W-1:0] DEPTH_LIMIT = 16'd10000;
	localparam logic [D_W-1:0]  DEN_OFF     = 46'd65536;
	localparam int              Z_FRAC      = 16;

	typedef struct packed {
		logic signed [VERT_W-1:0] vert_x;
		logic signed [VERT_W-1:0] vert_y;
		logic signed [VERT_W-1:0] vert_z;
	} vert_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] screen_x;
		logic signed [OUT_W-1:0] screen_y;
		logic signed [OUT_W-1:0] depth_z;
	} screen_out_t;

	// one slot of the divider pipeline, both lanes share the divisor
	typedef struct packed {
		logic                    valid;
		logic [D_W-1:0]          divisor;
		logic [D_W-1:0]          remx;
		logic [M_W-1:0]          nqx;
		logic                    negx;
		logic [D_W-1:0]          remy;
		logic [M_W-1:0]          nqy;
		logic                    negy;
		logic signed [OUT_W-1:0] depth;
	} div_stage_t;

endpackage

>>> design/vertex_perspective_project.sv
// ----------------------------------------------------------------------------
// vertex_perspective_project
// translate, rotate and perspective-project one 16.16 vertex to screen space
// ----------------------------------------------------------------------------
//  channel   signals                                  direction  content
//  input     in_valid, in_ready, in_data              in         one vertex x,y,z
//  output    out_valid, out_ready, out_data           out        screen x,y, depth
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in        register write
//
//  one vertex per cycle while the output is not stalled; a vertex passes through
//  73 register stages from input transaction to output valid: 8 arithmetic
//  stages, 63 divider stages (one quotient bit each, which sets the depth), 2
//  stages for the remainder by 32767
//  reset clears every valid bit; registers return to identity matrix, zero
//  translation, depth perception 10000 and a zero screen centre
//  a waiting output freezes the whole pipe; the first stage still takes a
//  vertex while it is empty, so a transaction can land during the stall
//  cfg_ready is always high; write registers only while the pipe is empty
// ----------------------------------------------------------------------------
module vertex_perspective_project #(
	parameter int COEF_WIDTH = 21
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  vpp_pkg::vert_in_t                      in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output vpp_pkg::screen_out_t                   out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [vpp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vpp_pkg::REG_W-1:0]              cfg_data
);

	localparam logic [vpp_pkg::REG_W-1:0] ONE_COEF = vpp_pkg::REG_W'(1) << vpp_pkg::COEF_FRAC;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [vpp_pkg::REG_W-1:0]  rows_q [3];
	logic [vpp_pkg::REG_W-1:0]  trans_q;
	logic [vpp_pkg::DP_W-1:0]   dp_q;
	logic [vpp_pkg::HALF_W-1:0] hw_q;
	logic [vpp_pkg::HALF_W-1:0] hh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= ONE_COEF;
			rows_q[1] <= ONE_COEF << COEF_WIDTH;
			rows_q[2] <= ONE_COEF << (2 * COEF_WIDTH);
			trans_q   <= '0;
			dp_q      <= vpp_pkg::DEPTH_LIMIT;
			hw_q      <= '0;
			hh_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vpp_pkg::REG_ROW0:  rows_q[0] <= cfg_data;
				vpp_pkg::REG_ROW1:  rows_q[1] <= cfg_data;
				vpp_pkg::REG_ROW2:  rows_q[2] <= cfg_data;
				vpp_pkg::REG_TRANS: trans_q   <= cfg_data;
				vpp_pkg::REG_DEPTH: dp_q      <= cfg_data[vpp_pkg::DP_W-1:0];
				vpp_pkg::REG_HALFW: hw_q      <= cfg_data[vpp_pkg::HALF_W-1:0];
				vpp_pkg::REG_HALFH: hh_q      <= cfg_data[vpp_pkg::HALF_W-1:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// flow control: global stall while the output transaction waits
	// ------------------------------------------------------------------
	logic en;
	logic ld1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s72, v_s73;

	assign en       = !v_s73 || out_ready;
	assign ld1      = en || !v_s1;
	assign in_ready = ld1;

	// ------------------------------------------------------------------
	// s1: add translation, offset is Q17.4 so shift up by 12
	// ------------------------------------------------------------------
	logic signed [vpp_pkg::T_W-1:0]    t_s1 [3];
	logic signed [vpp_pkg::T_W-1:0]    t_nxt [3];
	logic signed [vpp_pkg::VERT_W-1:0] vert [3];

	assign vert[0] = in_data.vert_x;
	assign vert[1] = in_data.vert_y;
	assign vert[2] = in_data.vert_z;

	always_comb begin
		logic signed [vpp_pkg::OFS_W-1:0] ofs;
		for (int k = 0; k < 3; k++) begin
			ofs      = trans_q[k*vpp_pkg::OFS_W +: vpp_pkg::OFS_W];
			t_nxt[k] = (vpp_pkg::T_W'(ofs) <<< vpp_pkg::COEF_FRAC) + vpp_pkg::T_W'(vert[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld1) begin
			v_s1 <= in_valid;
			t_s1 <= t_nxt;
		end
	end

	// ------------------------------------------------------------------
	// s2: nine coefficient products
	// ------------------------------------------------------------------
	logic signed [vpp_pkg::P_W-1:0] coef [3][3];
	logic signed [vpp_pkg::P_W-1:0] p_s2 [3][3];

	always_comb begin
		logic signed [COEF_WIDTH-1:0] cf;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				cf         = rows_q[r][k*COEF_WIDTH +: COEF_WIDTH];
				coef[r][k] = vpp_pkg::P_W'(cf);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					p_s2[r][k] <= coef[r][k] * vpp_pkg::P_W'(t_s1[k]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// s3: row sums
	// ------------------------------------------------------------------
	logic signed [vpp_pkg::S_W-1:0] sum_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			for (int r = 0; r < 3; r++) begin
				sum_s3[r] <= vpp_pkg::S_W'(p_s2[r][0]) + vpp_pkg::S_W'(p_s2[r][1])
				           + vpp_pkg::S_W'(p_s2[r][2]);
			end
		end
	end

	// ------------------------------------------------------------------
	// s4: drop 12 fraction bits, rounding toward zero
	// ------------------------------------------------------------------
	logic signed [vpp_pkg::Q_W-1:0] q_nxt [3];
	logic signed [vpp_pkg::Q_W-1:0] q_s4 [3];

	always_comb begin
		logic signed [vpp_pkg::S_W-1:0] sh;
		logic                           up;
		for (int r = 0; r < 3; r++) begin
			sh       = sum_s3[r] >>> vpp_pkg::COEF_FRAC;
			up       = sum_s3[r][vpp_pkg::S_W-1] && (sum_s3[r][vpp_pkg::COEF_FRAC-1:0] != '0);
			q_nxt[r] = vpp_pkg::Q_W'(sh) + vpp_pkg::Q_W'({1'b0, up});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			q_s4 <= q_nxt;
		end
	end

	// ------------------------------------------------------------------
	// s5: scale x,y by five, pick divisor and multiplier, depth output
	// ------------------------------------------------------------------
	logic signed [vpp_pkg::X_W-1:0]   x_s5, y_s5;
	logic [vpp_pkg::D_W-1:0]          div_s5;
	logic [vpp_pkg::MUL_W-1:0]        mul_s5;
	logic signed [vpp_pkg::OUT_W-1:0] dz_s5;

	logic signed [vpp_pkg::X_W-1:0]   x5, y5;
	logic signed [vpp_pkg::ZD_W-1:0]  zd;
	logic                             persp;
	logic signed [vpp_pkg::Q_W-1:0]   zsh, zt;
	logic signed [vpp_pkg::OUT_W-1:0] dz;

	always_comb begin
		x5    = (vpp_pkg::X_W'(q_s4[0]) <<< 2) + vpp_pkg::X_W'(q_s4[0]);
		y5    = (vpp_pkg::X_W'(q_s4[1]) <<< 2) + vpp_pkg::X_W'(q_s4[1]);
		zd    = vpp_pkg::ZD_W'(q_s4[2])
		      + vpp_pkg::ZD_W'($signed({1'b0, dp_q, {vpp_pkg::Z_FRAC{1'b0}}}));
		persp = (dp_q < vpp_pkg::DEPTH_LIMIT) && (zd > 0);
		// depth: truncate toward zero, then clamp to int16
		zsh   = q_s4[2] >>> vpp_pkg::Z_FRAC;
		zt    = zsh + vpp_pkg::Q_W'({1'b0, q_s4[2][vpp_pkg::Q_W-1]
		        && (q_s4[2][vpp_pkg::Z_FRAC-1:0] != '0)});
		if (zt > vpp_pkg::Q_W'(32767)) begin
			dz = 16'sh7fff;
		end else if (zt < -vpp_pkg::Q_W'(32768)) begin
			dz = -16'sh8000;
		end else begin
			dz = vpp_pkg::OUT_W'(zt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5   <= v_s4;
			x_s5   <= x5;
			y_s5   <= y5;
			div_s5 <= persp ? vpp_pkg::D_W'(zd) : vpp_pkg::DEN_OFF;
			mul_s5 <= persp ? dp_q[vpp_pkg::MUL_W-1:0] : vpp_pkg::MUL_W'(1);
			dz_s5  <= dz;
		end
	end

	// ------------------------------------------------------------------
	// s6: numerator products
	// ------------------------------------------------------------------
	logic signed [vpp_pkg::N_W-1:0]   px_s6, py_s6;
	logic [vpp_pkg::N_W-1:0]          hwd_s6, hhd_s6;
	logic [vpp_pkg::D_W-1:0]          div_s6;
	logic signed [vpp_pkg::OUT_W-1:0] dz_s6;
	logic signed [vpp_pkg::N_W-1:0]   mul_ext;

	assign mul_ext = vpp_pkg::N_W'($signed({1'b0, mul_s5}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6   <= v_s5;
			px_s6  <= vpp_pkg::N_W'(x_s5) * mul_ext;
			py_s6  <= vpp_pkg::N_W'(y_s5) * mul_ext;
			hwd_s6 <= vpp_pkg::N_W'(hw_q) * vpp_pkg::N_W'(div_s5);
			hhd_s6 <= vpp_pkg::N_W'(hh_q) * vpp_pkg::N_W'(div_s5);
			div_s6 <= div_s5;
			dz_s6  <= dz_s5;
		end
	end

	// ------------------------------------------------------------------
	// s7: numerators, x centred and y flipped
	// ------------------------------------------------------------------
	logic signed [vpp_pkg::N_W-1:0]   nx_s7, ny_s7;
	logic [vpp_pkg::D_W-1:0]          div_s7;
	logic signed [vpp_pkg::OUT_W-1:0] dz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7   <= v_s6;
			nx_s7  <= px_s6 + $signed(hwd_s6);
			ny_s7  <= $signed(hhd_s6) - py_s6;
			div_s7 <= div_s6;
			dz_s7  <= dz_s6;
		end
	end

	// ------------------------------------------------------------------
	// s8: sign and magnitude into the divider slot
	// ------------------------------------------------------------------
	vpp_pkg::div_stage_t div_s8;
	vpp_pkg::div_stage_t div_last;
	logic [vpp_pkg::N_W-1:0] magx, magy;

	assign magx = nx_s7[vpp_pkg::N_W-1] ? vpp_pkg::N_W'(-nx_s7) : vpp_pkg::N_W'(nx_s7);
	assign magy = ny_s7[vpp_pkg::N_W-1] ? vpp_pkg::N_W'(-ny_s7) : vpp_pkg::N_W'(ny_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s8.valid <= 1'b0;
		end else if (en) begin
			div_s8.valid   <= v_s7;
			div_s8.divisor <= div_s7;
			div_s8.remx    <= '0;
			div_s8.nqx     <= magx[vpp_pkg::M_W-1:0];
			div_s8.negx    <= nx_s7[vpp_pkg::N_W-1];
			div_s8.remy    <= '0;
			div_s8.nqy     <= magy[vpp_pkg::M_W-1:0];
			div_s8.negy    <= ny_s7[vpp_pkg::N_W-1];
			div_s8.depth   <= dz_s7;
		end
	end

	// s9..s71: quotient magnitude, one bit a stage
	vpp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.first (div_s8),
		.last  (div_last)
	);

	// ------------------------------------------------------------------
	// s72: fold 15-bit chunks, 2^15 is 1 modulo 32767
	// ------------------------------------------------------------------
	logic [vpp_pkg::FOLD_W-1:0]       fx_s72, fy_s72;
	logic                             negx_s72, negy_s72;
	logic signed [vpp_pkg::OUT_W-1:0] dz_s72;
	logic [vpp_pkg::FOLD_W-1:0]       fx, fy;

	always_comb begin
		fx = '0;
		fy = '0;
		for (int i = 0; i < vpp_pkg::MOD_CHUNKS; i++) begin
			fx = fx + vpp_pkg::FOLD_W'(vpp_pkg::MOD_W'(div_last.nqx >> (i * vpp_pkg::MOD_W)));
			fy = fy + vpp_pkg::FOLD_W'(vpp_pkg::MOD_W'(div_last.nqy >> (i * vpp_pkg::MOD_W)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s72 <= 1'b0;
		end else if (en) begin
			v_s72    <= div_last.valid;
			fx_s72   <= fx;
			fy_s72   <= fy;
			negx_s72 <= div_last.negx;
			negy_s72 <= div_last.negy;
			dz_s72   <= div_last.depth;
		end
	end

	// ------------------------------------------------------------------
	// s73: final fold, one subtract, sign of the dividend; output register
	// ------------------------------------------------------------------
	logic [vpp_pkg::MOD_W:0]          gx, gy;
	logic [vpp_pkg::MOD_W:0]          rx, ry;
	logic signed [vpp_pkg::OUT_W-1:0] sx, sy;
	vpp_pkg::screen_out_t             res_s73;

	always_comb begin
		gx = vpp_pkg::MOD_W'(fx_s72) + (vpp_pkg::MOD_W+1)'(fx_s72 >> vpp_pkg::MOD_W);
		gy = vpp_pkg::MOD_W'(fy_s72) + (vpp_pkg::MOD_W+1)'(fy_s72 >> vpp_pkg::MOD_W);
		rx = (gx >= vpp_pkg::SCREEN_MOD) ? gx - vpp_pkg::SCREEN_MOD : gx;
		ry = (gy >= vpp_pkg::SCREEN_MOD) ? gy - vpp_pkg::SCREEN_MOD : gy;
		sx = negx_s72 ? -$signed(rx) : $signed(rx);
		sy = negy_s72 ? -$signed(ry) : $signed(ry);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s73 <= 1'b0;
		end else if (en) begin
			v_s73            <= v_s72;
			res_s73.screen_x <= sx;
			res_s73.screen_y <= sy;
			res_s73.depth_z  <= dz_s72;
		end
	end

	assign out_valid = v_s73;
	assign out_data  = res_s73;

endmodule

>>> design/vpp_div.sv
// ----------------------------------------------------------------------------
// vpp_div
// pipelined restoring divider, one quotient bit per stage, two lanes
// ----------------------------------------------------------------------------
module vpp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  vpp_pkg::div_stage_t  first,
	output vpp_pkg::div_stage_t  last
);

	vpp_pkg::div_stage_t stg [vpp_pkg::M_W];

	for (genvar i = 0; i < vpp_pkg::M_W; i++) begin : g_step
		vpp_pkg::div_stage_t    cur;
		vpp_pkg::div_stage_t    nxt;
		logic [vpp_pkg::D_W:0]  shx;
		logic [vpp_pkg::D_W:0]  shy;
		logic [vpp_pkg::D_W:0]  dvs;
		logic                   gex;
		logic                   gey;

		if (i == 0) begin : g_head
			assign cur = first;
		end else begin : g_body
			assign cur = stg[i-1];
		end

		always_comb begin
			nxt = cur;
			dvs = {1'b0, cur.divisor};
			shx = {cur.remx, cur.nqx[vpp_pkg::M_W-1]};
			shy = {cur.remy, cur.nqy[vpp_pkg::M_W-1]};
			gex = (shx >= dvs);
			gey = (shy >= dvs);
			nxt.remx = gex ? vpp_pkg::D_W'(shx - dvs) : shx[vpp_pkg::D_W-1:0];
			nxt.remy = gey ? vpp_pkg::D_W'(shy - dvs) : shy[vpp_pkg::D_W-1:0];
			nxt.nqx = {cur.nqx[vpp_pkg::M_W-2:0], gex};
			nxt.nqy = {cur.nqy[vpp_pkg::M_W-2:0], gey};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg[i].valid <= 1'b0;
			end else if (en) begin
				stg[i] <= nxt;
			end
		end
	end

	assign last = stg[vpp_pkg::M_W-1];

endmodule

>>> design/vpp_check.sv
// ----------------------------------------------------------------------------
// vpp_check
// port-level checks of the projection pipeline, bound to the top level
// ----------------------------------------------------------------------------
module vpp_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input vpp_pkg::screen_out_t         out_data,
	input logic                         cfg_valid,
	input logic                         cfg_ready
);

	// a waiting result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// no result waiting means nothing stalls the input
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// register writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

	// screen values are reduced by 32767
	a_screen_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.screen_x >= -16'sd32766 && out_data.screen_x <= 16'sd32766
		&& out_data.screen_y >= -16'sd32766 && out_data.screen_y <= 16'sd32766)
		else $error("screen coordinate out of remainder range");

endmodule

bind vertex_perspective_project vpp_check u_vpp_check (.*);
